// ===== rtl/core/cft_pkg.sv =====
// Shared types, codes and limits for the CSV field tokenizer.
`timescale 1ns / 1ps

package cft_pkg;

	localparam int unsigned FIELD_LIMIT = 32;
	localparam int unsigned CHAR_LIMIT  = 255;
	localparam int unsigned FIELD_W     = 6;
	localparam int unsigned CNT_W       = 8;

	localparam logic [1:0] KIND_CHAR    = 2'd0;
	localparam logic [1:0] KIND_END     = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;
	localparam logic [1:0] KIND_DONE    = 2'd3;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W      = 2;
	localparam int unsigned LVL_W      = 3;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         char_value;
		logic [FIELD_W-1:0] field_index;
		logic               last;
	} result_t;

	typedef struct packed {
		logic               quoted_mode;
		logic               quote_pending;
		logic               skip_separators;
		logic               line_finished;
		logic [FIELD_W-1:0] fields_done;
		logic [CNT_W-1:0]   chars_in_field;
	} tok_state_t;

	typedef struct packed {
		logic [1:0]     count;
		result_t [1:0]  res;
	} step_out_t;

	function automatic logic [FIELD_W-1:0] sat_inc_fields(input logic [FIELD_W-1:0] fd);
		if (fd < FIELD_W'(FIELD_LIMIT))
			return fd + FIELD_W'(1);
		return fd;
	endfunction

endpackage

// ===== rtl/core/cft_step.sv =====
// Per-byte tokenizer rule: next state and up to two results for one item.
`timescale 1ns / 1ps

module cft_step (
	input  cft_pkg::tok_state_t st_cur,
	input  logic [7:0]          byte_value,
	input  logic                terminator,
	output cft_pkg::tok_state_t st_next,
	output cft_pkg::step_out_t  step_out
);
	import cft_pkg::*;

	always_comb begin
		tok_state_t    st;
		logic          go;
		logic [1:0]    n;
		result_t [1:0] r;

		st = st_cur;
		go = 1'b1;
		n  = 2'd0;
		r  = '0;

		if (terminator) begin
			if (!st.line_finished &&
			    (st.quote_pending || (st.chars_in_field != '0 && !st.quoted_mode))) begin
				r[n[0]] = '{kind: KIND_END, char_value: 8'd0,
				            field_index: st.fields_done, last: 1'b0};
				n = n + 2'd1;
				st.fields_done = sat_inc_fields(st.fields_done);
			end
			r[n[0]] = '{kind: KIND_DONE, char_value: 8'd0,
			            field_index: st.fields_done, last: 1'b0};
			n  = n + 2'd1;
			st = '0;
		end else if (st.line_finished) begin
			go = 1'b0;
		end else begin
			if (st.quote_pending) begin
				st.quote_pending = 1'b0;
				if (byte_value == CH_QUOTE) begin
					// doubled quote inside quotes stands for one quote
					if (st.chars_in_field < CNT_W'(CHAR_LIMIT)) begin
						r[n[0]] = '{kind: KIND_CHAR, char_value: CH_QUOTE,
						            field_index: st.fields_done, last: 1'b0};
						n = n + 2'd1;
						st.chars_in_field = st.chars_in_field + CNT_W'(1);
					end
					go = 1'b0;
				end else begin
					st.quoted_mode = 1'b0;
					r[n[0]] = '{kind: KIND_END, char_value: 8'd0,
					            field_index: st.fields_done, last: 1'b0};
					n = n + 2'd1;
					st.fields_done    = sat_inc_fields(st.fields_done);
					st.chars_in_field = '0;
					if (st.fields_done >= FIELD_W'(FIELD_LIMIT))
						st.line_finished = 1'b1;
					st.skip_separators = 1'b1;
					if (st.line_finished)
						go = 1'b0;
				end
			end

			if (go && st.skip_separators) begin
				if (byte_value == CH_SPACE || byte_value == CH_COMMA)
					go = 1'b0;
				else
					st.skip_separators = 1'b0;
			end

			if (go) begin
				if (!st.quoted_mode) begin
					if (byte_value == CH_SPACE) begin
						go = 1'b0;
					end else if (byte_value == CH_QUOTE) begin
						st.quoted_mode    = 1'b1;
						st.chars_in_field = '0;
						r[n[0]] = '{kind: KIND_RESTART, char_value: 8'd0,
						            field_index: st.fields_done, last: 1'b0};
						n  = n + 2'd1;
						go = 1'b0;
					end else if (byte_value == CH_COMMA) begin
						r[n[0]] = '{kind: KIND_END, char_value: 8'd0,
						            field_index: st.fields_done, last: 1'b0};
						n = n + 2'd1;
						st.fields_done    = sat_inc_fields(st.fields_done);
						st.chars_in_field = '0;
						if (st.fields_done >= FIELD_W'(FIELD_LIMIT))
							st.line_finished = 1'b1;
						go = 1'b0;
					end
				end else if (byte_value == CH_QUOTE) begin
					st.quote_pending = 1'b1;
					go = 1'b0;
				end
			end

			if (go) begin
				if (byte_value == CH_CR || byte_value == CH_LF) begin
					if (st.chars_in_field != '0) begin
						r[n[0]] = '{kind: KIND_END, char_value: 8'd0,
						            field_index: st.fields_done, last: 1'b0};
						n = n + 2'd1;
						st.fields_done = sat_inc_fields(st.fields_done);
					end
					st.chars_in_field = '0;
					st.line_finished  = 1'b1;
				end else if (st.chars_in_field < CNT_W'(CHAR_LIMIT)) begin
					r[n[0]] = '{kind: KIND_CHAR, char_value: byte_value,
					            field_index: st.fields_done, last: 1'b0};
					n = n + 2'd1;
					st.chars_in_field = st.chars_in_field + CNT_W'(1);
				end
			end
		end

		if (n == 2'd2)
			r[1].last = 1'b1;
		else if (n == 2'd1)
			r[0].last = 1'b1;

		st_next        = st;
		step_out.count = n;
		step_out.res   = r;
	end

endmodule

// ===== rtl/core/cft_result_fifo.sv =====
// Four-entry result queue: takes up to two results a cycle, sends one.
`timescale 1ns / 1ps

module cft_result_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  cft_pkg::step_out_t push,
	output logic               room,
	output logic               out_valid,
	input  logic               out_ready,
	output cft_pkg::result_t   out_res
);
	import cft_pkg::*;

	result_t           mem [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [LVL_W-1:0]  level_q;
	logic              pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (level_q != '0);
	assign out_res   = mem[rd_ptr_q];
	// two free entries regardless of this cycle's pop
	assign room      = (level_q <= LVL_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem[wr_ptr_q] <= push.res[0];
		if (push.count == 2'd2)
			mem[wr_ptr_q + PTR_W'(1)] <= push.res[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			level_q <= level_q + LVL_W'(push.count) - LVL_W'(pop);
		end
	end

`ifndef SYNTHESIS
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LVL_W'(FIFO_DEPTH))
		else $error("result queue over capacity");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count != 2'd0) |-> room)
		else $error("results pushed without two free entries");

	a_level_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (level_q == $past(level_q) + LVL_W'($past(push.count)) - LVL_W'($past(pop))))
		else $error("queue level does not follow push and pop");
`endif

endmodule

// ===== rtl/core/csv_field_tokenizer.sv =====
// Top level of the CSV field tokenizer: input stage, tokenizer state and result queue.
`timescale 1ns / 1ps

// Takes one CSV line a byte per transfer, ending with a transfer that has tlast set (its data is
// ignored), and sends field characters, field ends, field restarts and a line-done result that
// carries the field count; tuser gives the kind and tlast marks the final result of each input
// byte. A byte waits in the input register until the queue has room; the tokenizer rule runs on
// it there and writes its zero, one or two results into a four-entry queue, so a result passes
// the input register and the queue before it leaves. One byte is taken per cycle while the queue
// holds two or fewer results, so the sustained rate is one byte per cycle until bytes cause two
// results each, when the single result per cycle on the output side sets the pace.
module csv_field_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
	input  logic        s_axis_tlast,   // terminator
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] char_value, [13:8] field_index, [15:14] zero
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast    // last
);
	import cft_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       term_s1;
	logic       fire_s1;
	logic       room;

	tok_state_t state_q;
	tok_state_t state_next;
	step_out_t  step_out;
	step_out_t  push;
	result_t    head;

	assign fire_s1       = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			term_s1 <= s_axis_tlast;
		end
	end

	cft_step u_step (
		.st_cur     (state_q),
		.byte_value (byte_s1),
		.terminator (term_s1),
		.st_next    (state_next),
		.step_out   (step_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire_s1) begin
			state_q <= state_next;
		end
	end

	always_comb begin
		push = step_out;
		if (!fire_s1)
			push.count = 2'd0;
	end

	cft_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (head)
	);

	assign m_axis_tdata = {2'b00, head.field_index, head.char_value};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;

`ifndef SYNTHESIS
	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && term_s1) |=> (state_q == '0))
		else $error("terminator did not return tokenizer to reset state");

	a_term_done: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && term_s1) |-> (step_out.count != 2'd0 &&
			step_out.res[step_out.count[1]].kind == KIND_DONE))
		else $error("terminator without line done as final result");

	a_field_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.fields_done <= FIELD_W'(FIELD_LIMIT))
		else $error("field count passed its limit");
`endif

endmodule

// ===== dv/csv_field_tokenizer_tb.sv =====
// Self-checking testbench for the CSV field tokenizer: directed table, then random lines.
`timescale 1ns / 1ps

module csv_field_tokenizer_tb;
	import cft_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 60;
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASE_ITEMS   = 530;

	typedef struct {
		bit                 term;
		logic [7:0]         data;
		bit                 typed;
		int                 n;
		logic [1:0]         kind;
		logic [7:0]         ch;
		logic [FIELD_W-1:0] idx;
	} dir_row_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	csv_field_tokenizer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Directed rows; typed rows carry their one expected result (n = 0 means none).
	dir_row_t dir_rows [26] = '{
		'{1'b1, 8'hff,    1'b1, 1, KIND_DONE,    8'h00, 6'd0}, // empty line after reset
		'{1'b0, 8'h61,    1'b1, 1, KIND_CHAR,    8'h61, 6'd0},
		'{1'b0, CH_SPACE, 1'b1, 0, KIND_CHAR,    8'h00, 6'd0}, // dropped outside quotes
		'{1'b0, 8'hff,    1'b1, 1, KIND_CHAR,    8'hff, 6'd0},
		'{1'b0, CH_COMMA, 1'b1, 1, KIND_END,     8'h00, 6'd0},
		'{1'b0, CH_QUOTE, 1'b0, 0, KIND_CHAR,    8'h00, 6'd0}, // open quoted field
		'{1'b0, 8'h78,    1'b0, 0, KIND_CHAR,    8'h00, 6'd0},
		'{1'b0, CH_QUOTE, 1'b0, 0, KIND_CHAR,    8'h00, 6'd0},
		'{1'b0, CH_QUOTE, 1'b0, 0, KIND_CHAR,    8'h00, 6'd0}, // doubled quote
		'{1'b0, CH_QUOTE, 1'b0, 0, KIND_CHAR,    8'h00, 6'd0},
		'{1'b0, CH_SPACE, 1'b0, 0, KIND_CHAR,    8'h00, 6'd0}, // closes field
		'{1'b0, CH_COMMA, 1'b0, 0, KIND_CHAR,    8'h00, 6'd0}, // skipped after close
		'{1'b0, 8'h00,    1'b1, 1, KIND_CHAR,    8'h00, 6'd2},
		'{1'b0, CH_QUOTE, 1'b0, 0, KIND_CHAR,    8'h00, 6'd0}, // restart current field
		'{1'b0, CH_CR,    1'b0, 0, KIND_CHAR,    8'h00, 6'd0},
		'{1'b0, 8'h62,    1'b0, 0, KIND_CHAR,    8'h00, 6'd0}, // after CR: no result
		'{1'b1, 8'h00,    1'b1, 1, KIND_DONE,    8'h00, 6'd2},
		'{1'b0, CH_QUOTE, 1'b0, 0, KIND_CHAR,    8'h00, 6'd0},
		'{1'b0, 8'h71,    1'b0, 0, KIND_CHAR,    8'h00, 6'd0},
		'{1'b0, CH_QUOTE, 1'b0, 0, KIND_CHAR,    8'h00, 6'd0},
		'{1'b1, 8'h5a,    1'b0, 0, KIND_CHAR,    8'h00, 6'd0}, // pending quote at terminator
		'{1'b0, CH_QUOTE, 1'b0, 0, KIND_CHAR,    8'h00, 6'd0},
		'{1'b1, 8'h80,    1'b0, 0, KIND_CHAR,    8'h00, 6'd0}, // terminator inside quotes
		'{1'b0, 8'h63,    1'b0, 0, KIND_CHAR,    8'h00, 6'd0},
		'{1'b0, CH_LF,    1'b0, 0, KIND_CHAR,    8'h00, 6'd0},
		'{1'b1, 8'h01,    1'b0, 0, KIND_CHAR,    8'h00, 6'd0}
	};

	// tokenizer state as predicted
	logic               quoted_open = 1'b0;
	logic               quote_seen  = 1'b0;
	logic               skip_seps   = 1'b0;
	logic               line_done   = 1'b0;
	logic [FIELD_W-1:0] field_no    = '0;
	logic [CNT_W-1:0]   char_cnt    = '0;

	result_t    step_res [2];
	int         step_n;
	result_t    token_q [$];
	logic [7:0] line_bytes [$];

	bit      row_typed = 1'b0;
	int      row_n;
	result_t row_res;

	int mismatches   = 0;
	int accepted     = 0;
	int src_idle     = 0;
	int sink_idle    = 0;
	int hold_reqs    = 0;
	int hold_served  = 0;
	int hold_left    = 0;
	int stall_cycles = 0;

	task automatic post_result(input logic [1:0] kind, input logic [7:0] ch,
			input logic [FIELD_W-1:0] idx);
		if (step_n > 0)
			step_res[step_n-1].last = 1'b0;
		step_res[step_n].kind        = kind;
		step_res[step_n].char_value  = ch;
		step_res[step_n].field_index = idx;
		step_res[step_n].last        = 1'b1;
		step_n++;
	endtask

	task automatic close_field();
		post_result(KIND_END, 8'h00, field_no);
		if (field_no < FIELD_LIMIT)
			field_no++;
		char_cnt = '0;
		if (field_no >= FIELD_LIMIT)
			line_done = 1'b1;
	endtask

	task automatic take_char(input logic [7:0] b);
		if (char_cnt < CHAR_LIMIT) begin
			post_result(KIND_CHAR, b, field_no);
			char_cnt++;
		end
	endtask

	task automatic tokenize(input logic term, input logic [7:0] b);
		step_n = 0;
		if (term) begin
			if (!line_done) begin
				if (quote_seen)
					close_field();
				else if (char_cnt > 0 && !quoted_open)
					close_field();
			end
			post_result(KIND_DONE, 8'h00, field_no);
			quoted_open = 1'b0;
			quote_seen  = 1'b0;
			skip_seps   = 1'b0;
			line_done   = 1'b0;
			field_no    = '0;
			char_cnt    = '0;
			return;
		end
		if (line_done)
			return;
		if (quote_seen) begin
			quote_seen = 1'b0;
			if (b == CH_QUOTE) begin
				take_char(CH_QUOTE);
				return;
			end
			quoted_open = 1'b0;
			close_field();
			skip_seps = 1'b1;
			if (line_done)
				return;
		end
		if (skip_seps) begin
			if (b == CH_SPACE || b == CH_COMMA)
				return;
			skip_seps = 1'b0;
		end
		if (!quoted_open) begin
			if (b == CH_SPACE)
				return;
			if (b == CH_QUOTE) begin
				quoted_open = 1'b1;
				char_cnt    = '0;
				post_result(KIND_RESTART, 8'h00, field_no);
				return;
			end
			if (b == CH_COMMA) begin
				close_field();
				return;
			end
		end else if (b == CH_QUOTE) begin
			quote_seen = 1'b1;
			return;
		end
		if (b == CH_CR || b == CH_LF) begin
			if (char_cnt > 0)
				close_field();
			char_cnt  = '0;
			line_done = 1'b1;
			return;
		end
		take_char(b);
	endtask

	// called at a falling edge, returns at a falling edge with valid left high
	task automatic send_item(input logic term, input logic [7:0] b);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= term;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		tokenize(term, b);
		if (row_typed) begin
			if (row_n == 1)
				token_q.push_back(row_res);
			row_typed = 1'b0;
		end else begin
			for (int i = 0; i < step_n; i++)
				token_q.push_back(step_res[i]);
		end
		accepted++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (token_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_line();
		foreach (line_bytes[i])
			send_item(1'b0, line_bytes[i]);
		send_item(1'b1, 8'($urandom_range(255)));
		line_bytes.delete();
	endtask

	function automatic bit is_special(input logic [7:0] c);
		return c == CH_QUOTE || c == CH_COMMA || c == CH_SPACE || c == CH_CR || c == CH_LF;
	endfunction

	function automatic logic [7:0] text_byte();
		logic [7:0] c;
		if ($urandom_range(1) == 0)
			return 8'h61 + 8'($urandom_range(25));
		c = 8'($urandom_range(255));
		while (is_special(c))
			c = 8'($urandom_range(255));
		return c;
	endfunction

	task automatic add_plain(input int max_len);
		int len;
		len = $urandom_range(max_len);
		for (int i = 0; i < len; i++)
			line_bytes.push_back(($urandom_range(99) < 15) ? CH_SPACE : text_byte());
	endtask

	task automatic add_quoted(input int max_len);
		int len;
		int r;
		len = $urandom_range(max_len);
		if ($urandom_range(3) == 0)
			line_bytes.push_back(CH_SPACE);
		line_bytes.push_back(CH_QUOTE);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(99);
			if (r < 12) begin
				line_bytes.push_back(CH_QUOTE);
				line_bytes.push_back(CH_QUOTE);
			end else if (r < 22)
				line_bytes.push_back(CH_COMMA);
			else if (r < 30)
				line_bytes.push_back(CH_SPACE);
			else if (r < 32)
				line_bytes.push_back(CH_CR);
			else
				line_bytes.push_back(text_byte());
		end
		line_bytes.push_back(CH_QUOTE);
		repeat ($urandom_range(2))
			line_bytes.push_back(CH_SPACE);
	endtask

	// mostly well-formed lines; some hit the field limit, some are plain noise
	task automatic build_random_line();
		int pick;
		int nf;
		pick = $urandom_range(99);
		if (pick < 75) begin
			nf = $urandom_range(6);
			for (int f = 0; f < nf; f++) begin
				if (f > 0)
					line_bytes.push_back(CH_COMMA);
				if ($urandom_range(2) == 0)
					add_quoted(6);
				else
					add_plain(6);
			end
			case ($urandom_range(3))
				0: line_bytes.push_back(CH_CR);
				1: line_bytes.push_back(CH_LF);
				default: ;
			endcase
			if (line_bytes.size() != 0 && is_special(line_bytes[$]))
				repeat ($urandom_range(2))
					line_bytes.push_back(8'($urandom_range(255)));
		end else if (pick < 88) begin
			repeat ($urandom_range(12)) begin
				if ($urandom_range(1) == 0) begin
					case ($urandom_range(4))
						0: line_bytes.push_back(CH_QUOTE);
						1: line_bytes.push_back(CH_COMMA);
						2: line_bytes.push_back(CH_SPACE);
						3: line_bytes.push_back(CH_CR);
						default: line_bytes.push_back(CH_LF);
					endcase
				end else
					line_bytes.push_back(8'($urandom_range(255)));
			end
		end else begin
			nf = $urandom_range(28, 36);
			for (int f = 0; f < nf; f++) begin
				if (f > 0)
					line_bytes.push_back(CH_COMMA);
				if ($urandom_range(4) == 0)
					add_quoted(2);
				else
					add_plain(2);
			end
		end
	endtask

	// one field of 250 to 262 characters, around the character limit, then a short field
	task automatic build_long_line(input bit quoted);
		int len;
		len = $urandom_range(250, 262);
		if (quoted)
			line_bytes.push_back(CH_QUOTE);
		for (int i = 0; i < len; i++) begin
			if (quoted && $urandom_range(15) == 0) begin
				line_bytes.push_back(CH_QUOTE);
				line_bytes.push_back(CH_QUOTE);
			end else
				line_bytes.push_back(text_byte());
		end
		if (quoted)
			line_bytes.push_back(CH_QUOTE);
		line_bytes.push_back(CH_COMMA);
		line_bytes.push_back(8'h7a);
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// result side: random stalls plus requested long hold-offs
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_served != hold_reqs) begin
			hold_served++;
			hold_left = HOLD_CYCLES - 1;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= ($urandom_range(99) >= sink_idle);
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind        = m_axis_tuser;
			got.char_value  = m_axis_tdata[7:0];
			got.field_index = m_axis_tdata[13:8];
			got.last        = m_axis_tlast;
			if (token_q.size() == 0) begin
				mismatches++;
				$display("%0t ns: expected no result, got kind %0d char %0h index %0d last %0d",
					$time, got.kind, got.char_value, got.field_index, got.last);
			end else begin
				want = token_q.pop_front();
				check_field("kind", want.kind, got.kind);
				check_field("char_value", want.char_value, got.char_value);
				check_field("field_index", want.field_index, got.field_index);
				check_field("last", want.last, got.last);
			end
		end
	end

	// watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("csv_field_tokenizer: mismatch");
			$finish;
		end
	end

	initial begin
		int target;
		int lines;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			row_typed           = dir_rows[i].typed;
			row_n               = dir_rows[i].n;
			row_res.kind        = dir_rows[i].kind;
			row_res.char_value  = dir_rows[i].ch;
			row_res.field_index = dir_rows[i].idx;
			row_res.last        = 1'b1;
			send_item(dir_rows[i].term, dir_rows[i].data);
		end
		drain();

		target = accepted;
		for (int phase = 0; phase < 3; phase++) begin
			src_idle  = (phase == 0) ? 25 : (phase == 1) ? 46 : 0;
			sink_idle = (phase == 0) ? 46 : (phase == 1) ? 25 : 0;
			// long hold-off on the result side while bytes keep coming
			if (phase == 1)
				hold_reqs++;
			target += PHASE_ITEMS;
			lines = 0;
			while (accepted < target) begin
				if (lines == 2 && phase < 2)
					build_long_line(phase == 1);
				else
					build_random_line();
				send_line();
				lines++;
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("csv_field_tokenizer: match");
		else
			$display("csv_field_tokenizer: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/cft_pkg.sv
rtl/core/cft_step.sv
rtl/core/cft_result_fifo.sv
rtl/core/csv_field_tokenizer.sv
dv/csv_field_tokenizer_tb.sv
